[sv/tcaf_pkg.sv]
package tcaf_pkg;

  localparam int NODE_W        = 10;
  localparam int OPCODE_W      = 2;
  localparam int NODES_DEFAULT = 1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_EDGE  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef enum logic [1:0] {
    RES_MISS,
    RES_NODE_A,
    RES_MEET
  } res_src_e;

  // One parent-table entry: parent is meaningful only when has_parent is set.
  typedef struct packed {
    logic              has_parent;
    logic [NODE_W-1:0] parent;
  } entry_t;

  typedef struct packed {
    logic     edge_wr;
    logic     clr_init;
    logic     clr_wr;
    logic     walk_load;
    logic     walk_step;
    logic     res_en;
    res_src_e res_src;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic nodes_equal;
    logic meet;
    logic step_last;
    logic clr_last;
  } status_t;

endpackage

[sv/tcaf_ctrl.sv]
module tcaf_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic [tcaf_pkg::OPCODE_W-1:0]      opcode_i,
  input  tcaf_pkg::status_t                  status_i,
  output tcaf_pkg::cmd_t                     cmd_o,
  output logic                               busy
);

  tcaf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcaf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_src = tcaf_pkg::RES_MISS;
    busy          = 1'b1;
    case (state_q)
      tcaf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (tcaf_pkg::opcode_e'(opcode_i))
            tcaf_pkg::OP_EDGE: begin
              cmd_o.edge_wr = status_i.in_range;
            end
            tcaf_pkg::OP_QUERY: begin
              if (!status_i.in_range) begin
                cmd_o.res_en  = 1'b1;
                cmd_o.res_src = tcaf_pkg::RES_MISS;
              end else if (status_i.nodes_equal) begin
                cmd_o.res_en  = 1'b1;
                cmd_o.res_src = tcaf_pkg::RES_NODE_A;
              end else begin
                cmd_o.walk_load = 1'b1;
                state_d         = tcaf_pkg::ST_WALK;
              end
            end
            tcaf_pkg::OP_CLEAR: begin
              cmd_o.clr_init = 1'b1;
              state_d        = tcaf_pkg::ST_CLEAR;
            end
            default: begin
              // unused opcode: drop the transfer
            end
          endcase
        end
      end
      tcaf_pkg::ST_WALK: begin
        if (status_i.meet) begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_src = tcaf_pkg::RES_MEET;
          state_d       = tcaf_pkg::ST_IDLE;
        end else if (status_i.step_last) begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_src = tcaf_pkg::RES_MISS;
          state_d       = tcaf_pkg::ST_IDLE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      tcaf_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = tcaf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcaf_pkg::ST_IDLE;
      end
    endcase
  end

  a_walk_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcaf_pkg::ST_WALK && status_i.step_last) |=> (state_q == tcaf_pkg::ST_IDLE))
    else $error("walk ran past the step limit");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcaf_pkg::ST_CLEAR && status_i.clr_last) |=> (state_q == tcaf_pkg::ST_IDLE))
    else $error("clearing pass did not end at the last entry");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.edge_wr, cmd_o.clr_wr, cmd_o.walk_load, cmd_o.walk_step, cmd_o.clr_init}))
    else $error("conflicting datapath commands");

  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_en |-> (state_q == tcaf_pkg::ST_WALK || (start && !busy)))
    else $error("result issued without a query");

endmodule

[sv/tcaf_dp.sv]
module tcaf_dp #(
  parameter int NODES = tcaf_pkg::NODES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tcaf_pkg::NODE_W-1:0]   node_a_i,
  input  logic [tcaf_pkg::NODE_W-1:0]   node_b_i,
  input  tcaf_pkg::cmd_t                cmd_i,
  output tcaf_pkg::status_t             status_o,
  output logic [tcaf_pkg::NODE_W-1:0]   ancestor_o,
  output logic                          found_o,
  output logic                          result_strobe_o
);

  localparam int ADDR_W  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int STEP_W  = $clog2(2 * NODES);

  tcaf_pkg::entry_t mem_q [NODES];
  tcaf_pkg::entry_t rd_p_q, rd_q_q;

  logic [tcaf_pkg::NODE_W-1:0] a_q, b_q;
  logic [tcaf_pkg::NODE_W-1:0] p_next, q_next;
  logic [STEP_W-1:0]           steps_q;
  logic [ADDR_W-1:0]           clr_q;
  logic [ADDR_W-1:0]           rd_addr_p, rd_addr_q;
  logic [tcaf_pkg::NODE_W-1:0] anc_d;
  logic                        found_d;
  logic                        res_valid_q;
  logic [tcaf_pkg::NODE_W-1:0] anc_q;
  logic                        found_q;

  // Climb one level; a root jumps to the other query node.
  assign p_next = rd_p_q.has_parent ? rd_p_q.parent : b_q;
  assign q_next = rd_q_q.has_parent ? rd_q_q.parent : a_q;

  assign status_o.in_range    = (32'(node_a_i) < NODES) && (32'(node_b_i) < NODES);
  assign status_o.nodes_equal = (node_a_i == node_b_i);
  assign status_o.meet        = (p_next == q_next);
  assign status_o.step_last   = (steps_q == STEP_W'(2 * NODES - 1));
  assign status_o.clr_last    = (clr_q == ADDR_W'(NODES - 1));

  // Idle reads prefetch the query nodes so the first climb is ready on entry.
  always_comb begin
    if (cmd_i.walk_step) begin
      rd_addr_p = ADDR_W'(p_next);
      rd_addr_q = ADDR_W'(q_next);
    end else begin
      rd_addr_p = ADDR_W'(node_a_i);
      rd_addr_q = ADDR_W'(node_b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_wr) begin
      mem_q[ADDR_W'(node_b_i)] <= '{has_parent: 1'b1, parent: node_a_i};
    end else if (cmd_i.clr_wr) begin
      mem_q[clr_q] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_p_q <= mem_q[rd_addr_p];
    rd_q_q <= mem_q[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_load) begin
      a_q     <= node_a_i;
      b_q     <= node_b_i;
      steps_q <= '0;
    end else if (cmd_i.walk_step) begin
      steps_q <= steps_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_en;
      if (cmd_i.clr_init) begin
        clr_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_q <= status_o.clr_last ? '0 : clr_q + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    case (cmd_i.res_src)
      tcaf_pkg::RES_NODE_A: begin
        anc_d   = node_a_i;
        found_d = 1'b1;
      end
      tcaf_pkg::RES_MEET: begin
        anc_d   = p_next;
        found_d = 1'b1;
      end
      default: begin
        anc_d   = '0;
        found_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      anc_q   <= anc_d;
      found_q <= found_d;
    end
  end

  assign ancestor_o      = anc_q;
  assign found_o         = found_q;
  assign result_strobe_o = res_valid_q;

endmodule

[sv/tree_common_ancestor_finder.sv]
// Lowest common ancestor over a parent-pointer table of up to NODES nodes.
// A command transfers when start is high and busy is low. An edge command
// (node_a becomes the parent of node_b) is written at the transfer and leaves busy low;
// edges naming a node outside the table are dropped. A query answers with a
// one-cycle result_strobe_o carrying ancestor_o and found_o, which the
// receiver must take in that cycle. Queries with equal nodes or a node out of
// range answer in the next cycle. Otherwise two pointers climb the table one
// level per cycle, using both read ports of the table memory each cycle, and at
// most 2*NODES steps are made before answering found_o=0. A clear command, and
// reset itself, sweep the table one entry per cycle over all NODES entries
// (1024 at the default size), and busy stays high until the sweep has ended;
// only then is the next command taken.
module tree_common_ancestor_finder #(
  parameter int NODES = tcaf_pkg::NODES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tcaf_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [tcaf_pkg::NODE_W-1:0]   node_a_i,
  input  logic [tcaf_pkg::NODE_W-1:0]   node_b_i,
  output logic                          result_strobe_o,
  output logic [tcaf_pkg::NODE_W-1:0]   ancestor_o,
  output logic                          found_o
);

  tcaf_pkg::cmd_t    cmd;
  tcaf_pkg::status_t status;

  tcaf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  tcaf_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .ancestor_o      (ancestor_o),
    .found_o         (found_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES        = tcaf_pkg::NODES_DEFAULT;
  localparam int WALK_MAX     = 2 * NODES;
  localparam int TAIL_CYCLES  = WALK_MAX + 16;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RANDOM_ITEMS = 265;
  localparam logic [tcaf_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [tcaf_pkg::OPCODE_W-1:0] op;
    logic [tcaf_pkg::NODE_W-1:0]   a;
    logic [tcaf_pkg::NODE_W-1:0]   b;
    bit                            drain;
  } command_t;

  typedef struct {
    logic [tcaf_pkg::NODE_W-1:0] a;
    logic [tcaf_pkg::NODE_W-1:0] b;
    logic [tcaf_pkg::NODE_W-1:0] ancestor;
    logic                        found;
  } lca_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [tcaf_pkg::OPCODE_W-1:0] opcode_i = tcaf_pkg::OP_EDGE;
  logic [tcaf_pkg::NODE_W-1:0]   node_a_i = '0;
  logic [tcaf_pkg::NODE_W-1:0]   node_b_i = '0;
  logic                          result_strobe_o;
  logic [tcaf_pkg::NODE_W-1:0]   ancestor_o;
  logic                          found_o;

  command_t                    command_q[$];
  lca_t                        lca_q[$];
  logic [tcaf_pkg::NODE_W-1:0] parent_of[NODES];
  bit                          has_parent[NODES];

  int unsigned cycles;
  int unsigned errors;
  int unsigned sent_cnt;
  int unsigned taken_cnt;
  int unsigned n_edges;
  int unsigned n_queries;
  int unsigned n_unmet;
  int unsigned n_clears;
  int unsigned n_ignored;

  tree_common_ancestor_finder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .result_strobe_o (result_strobe_o),
    .ancestor_o      (ancestor_o),
    .found_o         (found_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, lca_q.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // Two pointers climb; a pointer at a root jumps to the other query node.
  function automatic void predict_lca(input logic [tcaf_pkg::NODE_W-1:0] a,
                                      input logic [tcaf_pkg::NODE_W-1:0] b,
                                      output logic [tcaf_pkg::NODE_W-1:0] anc,
                                      output logic hit);
    logic [tcaf_pkg::NODE_W-1:0] p;
    logic [tcaf_pkg::NODE_W-1:0] q;
    anc = '0;
    hit = 1'b0;
    if (a == b) begin
      anc = a;
      hit = 1'b1;
      return;
    end
    p = a;
    q = b;
    for (int step = 0; step < WALK_MAX; step++) begin
      p = has_parent[p] ? parent_of[p] : b;
      q = has_parent[q] ? parent_of[q] : a;
      if (p == q) begin
        anc = p;
        hit = 1'b1;
        return;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input lca_t want,
                                 input logic [tcaf_pkg::NODE_W-1:0] got_anc,
                                 input logic got_found);
    $display("[%0t] MISMATCH %s: query (%0d,%0d) want ancestor=%0d found=%0b, got %0d/%0b",
             $realtime, what, want.a, want.b, want.ancestor, want.found, got_anc, got_found);
    errors++;
  endtask

  task automatic add_item(input logic [tcaf_pkg::OPCODE_W-1:0] op, input int a, input int b,
                          input bit drain = 1'b0);
    command_t c;
    c.op    = op;
    c.a     = a[tcaf_pkg::NODE_W-1:0];
    c.b     = b[tcaf_pkg::NODE_W-1:0];
    c.drain = drain;
    command_q.push_back(c);
  endtask

  // Monitor: check strobed results, then track the transfer taken at this edge.
  always @(posedge clk_i) begin : monitor
    lca_t want;
    lca_t none;
    none = '{default: '0};
    if (rst_ni) begin
      if (result_strobe_o === 1'b1) begin
        if (lca_q.size() == 0) begin
          report_mismatch("result with nothing pending", none, ancestor_o, found_o);
        end else begin
          want = lca_q.pop_front();
          if (ancestor_o !== want.ancestor)
            report_mismatch("ancestor", want, ancestor_o, found_o);
          if (found_o !== want.found)
            report_mismatch("found", want, ancestor_o, found_o);
        end
      end
      if (start && busy === 1'b0) begin
        taken_cnt++;
        case (opcode_i)
          tcaf_pkg::OP_EDGE: begin
            parent_of[node_b_i] = node_a_i;
            has_parent[node_b_i] = 1'b1;
            n_edges++;
          end
          tcaf_pkg::OP_QUERY: begin
            want.a = node_a_i;
            want.b = node_b_i;
            predict_lca(node_a_i, node_b_i, want.ancestor, want.found);
            if (!want.found) n_unmet++;
            lca_q.push_back(want);
            n_queries++;
          end
          tcaf_pkg::OP_CLEAR: begin
            has_parent = '{default: 1'b0};
            n_clears++;
          end
          default: n_ignored++;
        endcase
      end
    end
  end

  // Driver: one command at a time; hold it until the transfer, idle at random between.
  always @(negedge clk_i) begin : driver
    command_t                      c;
    logic                          nxt_start;
    logic [tcaf_pkg::OPCODE_W-1:0] nxt_op;
    logic [tcaf_pkg::NODE_W-1:0]   nxt_a;
    logic [tcaf_pkg::NODE_W-1:0]   nxt_b;
    logic [31:0]                   rnd;
    bit                            go;
    bit                            calm;
    nxt_start = start;
    nxt_op    = opcode_i;
    nxt_a     = node_a_i;
    nxt_b     = node_b_i;
    if (rst_ni && sent_cnt == taken_cnt) begin
      nxt_start = 1'b0;
      rnd       = $urandom;
      nxt_op    = rnd[tcaf_pkg::OPCODE_W-1:0];
      rnd       = $urandom;
      nxt_a     = rnd[tcaf_pkg::NODE_W-1:0];
      rnd       = $urandom;
      nxt_b     = rnd[tcaf_pkg::NODE_W-1:0];
      if (command_q.size() > 0) begin
        calm = (sent_cnt >= 130 && sent_cnt < 190);
        go = calm || ($urandom_range(99) >= 14);
        // hold off until every pending query has answered
        if (command_q[0].drain && lca_q.size() != 0) go = 1'b0;
        if (go) begin
          c = command_q.pop_front();
          nxt_start = 1'b1;
          nxt_op    = c.op;
          nxt_a     = c.a;
          nxt_b     = c.b;
          sent_cnt++;
        end
      end
    end
    start    <= nxt_start;
    opcode_i <= nxt_op;
    node_a_i <= nxt_a;
    node_b_i <= nxt_b;
  end

  initial begin : stimulus
    int nodes[$];
    int counted;
    int k;
    int pick;
    int n_q;
    int par;
    int node;
    bit fresh;
    bit chain;

    // empty table: distinct nodes, then equal nodes at both extremes
    add_item(tcaf_pkg::OP_QUERY, 0, 1023);
    add_item(tcaf_pkg::OP_QUERY, 1023, 1023);
    add_item(tcaf_pkg::OP_QUERY, 0, 0);
    // small tree: 0 -> {1023, 5}, 5 -> 1
    add_item(tcaf_pkg::OP_EDGE, 0, 1023);
    add_item(tcaf_pkg::OP_EDGE, 0, 5);
    add_item(tcaf_pkg::OP_EDGE, 5, 1);
    add_item(tcaf_pkg::OP_QUERY, 1, 1023);
    add_item(tcaf_pkg::OP_QUERY, 5, 1);
    add_item(tcaf_pkg::OP_QUERY, 1023, 0);
    // re-parent 5 under 1023
    add_item(tcaf_pkg::OP_EDGE, 1023, 5);
    add_item(tcaf_pkg::OP_QUERY, 1, 0);
    add_item(tcaf_pkg::OP_QUERY, 1, 1023);
    add_item(OP_UNUSED, 682, 341);
    // close a cycle through the root
    add_item(tcaf_pkg::OP_EDGE, 1, 0);
    add_item(tcaf_pkg::OP_QUERY, 5, 1023, 1'b1);
    add_item(tcaf_pkg::OP_CLEAR, 1023, 0);
    add_item(tcaf_pkg::OP_EDGE, 682, 341);
    add_item(tcaf_pkg::OP_EDGE, 341, 1022);
    add_item(tcaf_pkg::OP_QUERY, 1022, 682);
    add_item(tcaf_pkg::OP_EDGE, 1022, 5);
    add_item(tcaf_pkg::OP_QUERY, 5, 682);
    add_item(tcaf_pkg::OP_QUERY, 341, 5, 1'b1);

    // random trees, each loaded then queried, with some noise mixed in
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      nodes.delete();
      if ($urandom_range(99) < 70) begin
        add_item(tcaf_pkg::OP_CLEAR, $urandom, $urandom, $urandom_range(99) < 20);
        counted++;
      end
      chain = ($urandom_range(99) < 30);
      k = chain ? $urandom_range(6, 24) : $urandom_range(3, 14);
      for (int i = 0; i < k; i++) begin
        do begin
          node = $urandom_range(NODES - 1);
          fresh = 1'b1;
          foreach (nodes[j]) if (nodes[j] == node) fresh = 1'b0;
        end while (!fresh);
        nodes.push_back(node);
        if (i > 0) begin
          par = chain ? nodes[i-1] : nodes[$urandom_range(i - 1)];
          add_item(tcaf_pkg::OP_EDGE, par, node, $urandom_range(99) < 3);
          counted++;
        end
      end
      n_q = $urandom_range(4, 10);
      for (int i = 0; i < n_q; i++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          add_item(tcaf_pkg::OP_QUERY, $urandom, $urandom);
          counted++;
        end else if (pick < 8) begin
          add_item(OP_UNUSED, $urandom, $urandom);
        end else if (pick < 12) begin
          // move a subtree under another node of the same tree
          add_item(tcaf_pkg::OP_EDGE, nodes[0], nodes[$urandom_range(1, k - 1)]);
          counted++;
        end else if (pick < 18) begin
          node = nodes[$urandom_range(k - 1)];
          add_item(tcaf_pkg::OP_QUERY, node, node);
          counted++;
        end else begin
          add_item(tcaf_pkg::OP_QUERY,
                   nodes[$urandom_range(k - 1)], nodes[$urandom_range(k - 1)],
                   $urandom_range(99) < 3);
          counted++;
        end
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (command_q.size() == 0 && sent_cnt == taken_cnt);
    wait (lca_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d transfers: %0d edges, %0d clears, %0d ignored opcodes",
             taken_cnt, n_edges, n_clears, n_ignored);
    $display("%0d ancestor queries, %0d of them without a meeting point, in %0d cycles",
             n_queries, n_unmet, cycles);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
